/* hdl/gpe_pkg.sv */
package gpe_pkg;

  // Default number of vertices the matrix is built for.
  localparam int VERTICES_DEF = 16;

  // Field and register widths.
  localparam int VID_W = 4;
  localparam int CFG_W = 5;
  // Wide enough to hold any vertex count up to 127.
  localparam int CNT_W = 7;

  localparam logic [CFG_W-1:0] VCOUNT_RST = 5'd16;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t             command;
    logic [VID_W-1:0] first_vertex;
    logic [VID_W-1:0] second_vertex;
  } in_item_t;

  typedef struct packed {
    logic path_exists;
    logic bad_vertex;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

  // Commands from the controller to every cell of the chain.
  typedef struct packed {
    logic wr_edge;
    logic start;
    logic step;
  } cell_ctl_t;

endpackage

/* hdl/graph_path_exists.sv */
// Operation: an edge transaction is written into the matrix as it is taken and gives no result.
// A query is taken, then runs P expansion passes (P is at most VERTICES: one more than the
// farthest hop count from the source), then loads the output register once that register is free.
// Throughput: a query occupies the block until its result is loaded; edges go one per cycle while no query is running.
// An out-of-range query skips the passes and goes straight to loading its result.
// Reset (synchronous, rst_n low) clears the adjacency matrix and sets the vertex count to 16.
module graph_path_exists #(
  parameter int VERTICES = gpe_pkg::VERTICES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  gpe_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output gpe_pkg::out_item_t             out_data,
  input  logic                           cfg_wr_en,
  input  logic [gpe_pkg::CFG_W-1:0]      cfg_wr_data
);
  import gpe_pkg::*;

  logic [CFG_W-1:0]    vertex_count_r;
  logic [CNT_W-1:0]    live_cnt;
  logic                range_ok;
  logic [VERTICES-1:0] a_oh;
  logic [VERTICES-1:0] b_oh;
  logic [VERTICES-1:0] dst_oh;
  logic [VERTICES-1:0] live_vec;
  logic [VERTICES-1:0] reach_vec;
  logic [VERTICES:0]   grew_c;
  logic [VID_W-1:0]    dst_r;
  logic                hit;
  cell_ctl_t           ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= VCOUNT_RST;
    end else if (cfg_wr_en) begin
      vertex_count_r <= cfg_wr_data;
    end
  end

  // Destination of the running query.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dst_r <= in_data.second_vertex;
    end
  end

  always_comb begin
    if (CNT_W'(vertex_count_r) >= CNT_W'(VERTICES)) begin
      live_cnt = CNT_W'(VERTICES);
    end else begin
      live_cnt = CNT_W'(vertex_count_r);
    end
    range_ok = (CNT_W'(in_data.first_vertex) < live_cnt) &&
               (CNT_W'(in_data.second_vertex) < live_cnt);
    for (int k = 0; k < VERTICES; k++) begin
      a_oh[k]   = (CNT_W'(in_data.first_vertex) == CNT_W'(k));
      b_oh[k]   = (CNT_W'(in_data.second_vertex) == CNT_W'(k));
      dst_oh[k] = (CNT_W'(dst_r) == CNT_W'(k));
    end
    hit = |(reach_vec & dst_oh);
  end

  assign grew_c[0] = 1'b0;

  for (genvar j = 0; j < VERTICES; j++) begin : g_cell
    assign live_vec[j] = (CNT_W'(j) < live_cnt);

    gpe_cell #(
      .VERTICES (VERTICES),
      .IDX      (j)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .live     (live_vec[j]),
      .a_oh     (a_oh),
      .b_oh     (b_oh),
      .reach    (reach_vec),
      .grew_in  (grew_c[j]),
      .reached  (reach_vec[j]),
      .grew_out (grew_c[j+1])
    );
  end

  gpe_ctrl #(
    .VERTICES (VERTICES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_data.command),
    .range_ok  (range_ok),
    .grew      (grew_c[VERTICES]),
    .hit       (hit),
    .ctl       (ctl),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* hdl/gpe_cell.sv */
module gpe_cell #(
  parameter int VERTICES = gpe_pkg::VERTICES_DEF,
  parameter int IDX      = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gpe_pkg::cell_ctl_t  ctl,
  input  logic                live,
  input  logic [VERTICES-1:0] a_oh,
  input  logic [VERTICES-1:0] b_oh,
  input  logic [VERTICES-1:0] reach,
  input  logic                grew_in,
  output logic                reached,
  output logic                grew_out
);
  import gpe_pkg::*;

  logic [VERTICES-1:0] row_r;
  logic [VERTICES-1:0] row_nxt;
  logic                reached_r;
  logic                reached_nxt;

  // The matrix is symmetric, so this row is also this vertex's column: the
  // vertex, if live, joins the reached set when any reached vertex is a neighbor.
  always_comb begin
    row_nxt = row_r;
    if (ctl.wr_edge) begin
      if (a_oh[IDX]) begin
        row_nxt = row_nxt | b_oh;
      end
      if (b_oh[IDX]) begin
        row_nxt = row_nxt | a_oh;
      end
    end

    reached_nxt = reached_r;
    if (ctl.start) begin
      reached_nxt = a_oh[IDX];
    end else if (ctl.step) begin
      reached_nxt = reached_r | (live & (|(row_r & reach)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      reached_r <= 1'b0;
    end else begin
      row_r     <= row_nxt;
      reached_r <= reached_nxt;
    end
  end

  assign reached  = reached_r;
  assign grew_out = grew_in | (reached_nxt != reached_r);

endmodule

/* hdl/gpe_ctrl.sv */
module gpe_ctrl #(
  parameter int VERTICES = gpe_pkg::VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gpe_pkg::cmd_t       in_cmd,
  input  logic                range_ok,
  input  logic                grew,
  input  logic                hit,
  output gpe_pkg::cell_ctl_t  ctl,
  output logic                out_valid,
  input  logic                out_ready,
  output gpe_pkg::out_item_t  out_data
);
  import gpe_pkg::*;

  localparam int PASS_W = $clog2(VERTICES + 1);

  state_t            state_r;
  state_t            state_nxt;
  logic [PASS_W-1:0] pass_r;
  logic [PASS_W-1:0] pass_nxt;
  logic              bad_r;
  logic              bad_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  out_item_t         out_data_r;
  out_item_t         out_data_nxt;
  logic              accept;

  always_comb begin
    in_ready = (state_r == ST_IDLE);
    accept   = in_valid && in_ready;

    ctl.wr_edge = accept && (in_cmd == CMD_ADD) && range_ok;
    ctl.start   = accept && (in_cmd == CMD_QUERY) && range_ok;
    ctl.step    = (state_r == ST_SEARCH);

    state_nxt     = state_r;
    pass_nxt      = pass_r;
    bad_nxt       = bad_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        if (accept && (in_cmd == CMD_QUERY)) begin
          bad_nxt = !range_ok;
          if (range_ok) begin
            pass_nxt  = '0;
            state_nxt = ST_SEARCH;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SEARCH: begin
        // One expansion pass per cycle; stop once the set stops growing or the pass limit is reached.
        pass_nxt = pass_r + 1'b1;
        if (!grew || (pass_r == PASS_W'(VERTICES - 1))) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.path_exists = hit && !bad_r;
          out_data_nxt.bad_vertex  = bad_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pass_r      <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (pass_r < PASS_W'(VERTICES)))
    else $error("search ran past the pass limit");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result raised outside the done state");

  a_start_searches: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> (state_r == ST_SEARCH))
    else $error("query started without a search");

  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.wr_edge && ctl.start) && !(ctl.step && (ctl.wr_edge || ctl.start)))
    else $error("conflicting cell commands");

endmodule

/* sim/graph_path_exists_test.sv */
`timescale 1ns / 100ps

module graph_path_exists_test;
  import gpe_pkg::*;

  localparam int NV         = VERTICES_DEF;
  // Wait long enough for a query to run all its passes and load its result, with some margin.
  localparam int SETTLE     = NV + 4;
  localparam int IDLE_LIMIT = 2000;
  localparam int REPORT_MAX = 20;

  logic             clk;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  in_item_t         in_data     = '0;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  out_item_t        out_data;
  logic             cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = VCOUNT_RST;

  // Local copy of the graph and the vertex count register.
  logic [NV-1:0]    adj_rows [NV];
  logic [CFG_W-1:0] vcount_model = VCOUNT_RST;
  out_item_t        pending_answers [$];

  int gap_pct        = 0;
  int stall_pct      = 0;
  int hold_cycles    = 0;
  int idle_cycles    = 0;
  int mismatch_count = 0;
  int checked_count  = 0;
  int edge_count     = 0;
  int query_count    = 0;
  int reach_count    = 0;
  int flag_count     = 0;
  int setting_count  = 0;

  graph_path_exists u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_idle(input int pct);
    if (pct == 0 || $urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  function automatic int live_count();
    return (int'(vcount_model) < NV) ? int'(vcount_model) : NV;
  endfunction

  // Mostly vertices in use, now and then any vertex the field can name.
  function automatic int pick_vertex(input int n);
    if (n == 0 || $urandom_range(7) == 0) return $urandom_range(15);
    return $urandom_range(n - 1);
  endfunction

  function automatic in_item_t make_item(input cmd_t cmd, input int a, input int b);
    in_item_t item;
    item.command       = cmd;
    item.first_vertex  = VID_W'(a);
    item.second_vertex = VID_W'(b);
    return item;
  endfunction

  // Applies one transaction to the local graph and returns the answer a query gives.
  function automatic out_item_t apply_to_graph(input in_item_t item);
    out_item_t     answer;
    int            n;
    int            a;
    int            b;
    int            i;
    int            pass;
    logic [NV-1:0] live;
    logic [NV-1:0] reach;
    logic [NV-1:0] grown;
    n = live_count();
    a = int'(item.first_vertex);
    b = int'(item.second_vertex);
    answer = '0;
    live = '0;
    for (i = 0; i < n; i++) live[i] = 1'b1;
    if (item.command == CMD_ADD) begin
      if (a < n && b < n) begin
        adj_rows[a][b] = 1'b1;
        adj_rows[b][a] = 1'b1;
      end
    end else if (a >= n || b >= n) begin
      answer.bad_vertex = 1'b1;
    end else begin
      reach = '0;
      reach[a] = 1'b1;
      for (pass = 0; pass < NV; pass++) begin
        grown = reach;
        for (i = 0; i < n; i++)
          if (reach[i]) grown |= adj_rows[i];
        grown &= live;
        if (grown == reach) break;
        reach = grown;
      end
      answer.path_exists = reach[b];
    end
    return answer;
  endfunction

  // Valid is left high after a transaction so that back-to-back items never
  // lower and raise it within one time step.
  task automatic send_item(input in_item_t item);
    int        gap;
    out_item_t answer;
    gap = pick_idle(gap_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    answer = apply_to_graph(item);
    if (item.command == CMD_QUERY) begin
      pending_answers.insert(pending_answers.size(), answer);
      query_count++;
      if (answer.path_exists) reach_count++;
      if (answer.bad_vertex) flag_count++;
    end else begin
      edge_count++;
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_vertex_count(input int value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    vcount_model = CFG_W'(value);
    setting_count++;
  endtask

  task automatic test_empty_graph();
    gap_pct   = 0;
    stall_pct = 0;
    send_item(make_item(CMD_QUERY, 0, 0));
    send_item(make_item(CMD_QUERY, 0, 15));
    send_item(make_item(CMD_QUERY, 15, 15));
  endtask

  task automatic test_edge_basics();
    gap_pct   = 20;
    stall_pct = 20;
    send_item(make_item(CMD_ADD, 0, 15));
    send_item(make_item(CMD_QUERY, 15, 0));
    // A self-loop sets a bit but connects nothing.
    send_item(make_item(CMD_ADD, 7, 7));
    send_item(make_item(CMD_QUERY, 7, 8));
    send_item(make_item(CMD_QUERY, 7, 7));
  endtask

  task automatic test_vertex_count();
    set_vertex_count(4);
    send_item(make_item(CMD_QUERY, 0, 3));
    send_item(make_item(CMD_ADD, 0, 3));
    send_item(make_item(CMD_QUERY, 3, 0));
    send_item(make_item(CMD_ADD, 2, 9));
    send_item(make_item(CMD_QUERY, 2, 9));
    set_vertex_count(1);
    send_item(make_item(CMD_QUERY, 0, 0));
    send_item(make_item(CMD_QUERY, 0, 1));
    set_vertex_count(0);
    send_item(make_item(CMD_ADD, 0, 0));
    send_item(make_item(CMD_QUERY, 0, 0));
    // Edges stored before the count shrank must still be there.
    set_vertex_count(31);
    send_item(make_item(CMD_QUERY, 15, 3));
  endtask

  // Builds a path through all vertices so the search needs every pass.
  task automatic test_long_path();
    int chain [NV];
    int order [NV-1];
    int i;
    int j;
    int tmp;
    chain = '{3, 0, 15, 1, 2, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14};
    for (i = 0; i < NV - 1; i++) order[i] = i;
    for (i = NV - 2; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    set_vertex_count(16);
    gap_pct   = 30;
    stall_pct = 30;
    for (i = 0; i < NV - 1; i++)
      send_item(make_item(CMD_ADD, chain[order[i]], chain[order[i] + 1]));
    send_item(make_item(CMD_QUERY, 3, 14));
    send_item(make_item(CMD_QUERY, 14, 3));
    send_item(make_item(CMD_QUERY, 15, 14));
    // Dropping vertex 15 cuts the path in two.
    set_vertex_count(15);
    send_item(make_item(CMD_QUERY, 3, 14));
    send_item(make_item(CMD_QUERY, 1, 14));
  endtask

  task automatic test_random_traffic();
    int counts [14];
    int p;
    int n;
    int sent;
    int reps;
    counts = '{31, 9, 1, 0, 5, 12, 2, 15, 7, 20, 3, 14, 16, 0};
    counts[13] = $urandom_range(31);
    for (p = 0; p < 14; p++) begin
      set_vertex_count(counts[p]);
      n = live_count();
      case (p % 3)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 25;
          stall_pct = 40;
        end
        default: begin
          gap_pct   = 60;
          stall_pct = 15;
        end
      endcase
      sent = 0;
      while (sent < 56) begin
        if ($urandom_range(9) < 7) begin
          // An occasional new edge followed by a burst of random queries.
          if ($urandom_range(3) == 0) begin
            send_item(make_item(CMD_ADD, pick_vertex(n), pick_vertex(n)));
            sent++;
          end
          reps = $urandom_range(5, 2);
          repeat (reps) send_item(make_item(CMD_QUERY, pick_vertex(n), pick_vertex(n)));
          sent += reps;
        end else begin
          send_item(make_item(($urandom_range(3) == 0) ? CMD_ADD : CMD_QUERY,
                              $urandom_range(15), $urandom_range(15)));
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      checked_count++;
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("%0t: result with no query waiting: path_exists=%0b bad_vertex=%0b",
                   $time, out_data.path_exists, out_data.bad_vertex);
      end else begin
        want = pending_answers.pop_front();
        if (out_data.path_exists !== want.path_exists ||
            out_data.bad_vertex !== want.bad_vertex) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("%0t: expected path_exists/bad_vertex=%0b/%0b, got %0b/%0b",
                     $time, want.path_exists, want.bad_vertex,
                     out_data.path_exists, out_data.bad_vertex);
        end
      end
    end
    if (hold_cycles > 0) hold_cycles--;
    else hold_cycles = pick_idle(stall_pct);
    out_ready <= (hold_cycles == 0);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, idle_cycles, pending_answers.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    foreach (adj_rows[v]) adj_rows[v] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_graph();
    test_edge_basics();
    test_vertex_count();
    test_long_path();
    test_random_traffic();
    drain_results();
    $display("Sent %0d edge and %0d query transactions across %0d vertex-count settings.",
             edge_count, query_count, setting_count);
    $display("Queries: %0d reachable, %0d out of range; %0d results checked, %0d mismatches.",
             reach_count, flag_count, checked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
